[hw/rtl/otrs_pkg.sv]
// Package: shared constants and divider channel types for the trimmed statistics block.
`timescale 1ns / 1ps
package otrs_pkg;
   localparam int OTRS_SLOTS     = 4;
   localparam int OTRS_COST_BITS = 32;
   localparam int DVD_BITS       = 64;
   localparam int DVS_BITS       = 32;

   typedef struct packed {
      logic                start;
      logic [DVD_BITS-1:0] dividend;
      logic [DVS_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DVD_BITS-1:0] quotient;
   } div_rsp_type;
endpackage

[hw/rtl/otrs_cell.sv]
// Module: one slot of the sorted list of largest samples.
`timescale 1ns / 1ps
module otrs_cell #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  logic [W-1:0] sample,
   input  logic [W-1:0] upper,
   output logic [W-1:0] value
);
   logic [W-1:0] slot_ff, slot_in, hi;

   // clamp the new sample between own value and the upper neighbour
   always_comb begin
      hi      = (sample >= slot_ff) ? sample : slot_ff;
      slot_in = (hi >= upper) ? upper : hi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (load) begin
         slot_ff <= slot_in;
      end
   end

   assign value = slot_ff;
endmodule

[hw/rtl/otrs_div.sv]
// Module: restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module otrs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  otrs_pkg::div_req_type req,
   output otrs_pkg::div_rsp_type rsp
);
   import otrs_pkg::*;

   logic [DVD_BITS-1:0] quo_ff, quo_in;
   logic [DVS_BITS-1:0] rem_ff, rem_in;
   logic [DVS_BITS-1:0] dvs_ff;
   logic [5:0]          cnt_ff;
   logic                busy_ff, done_ff;
   logic [DVS_BITS:0]   trial;

   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_BITS-1]};
      quo_in = {quo_ff[DVD_BITS-2:0], 1'b0};
      rem_in = trial[DVS_BITS-1:0];
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in    = DVS_BITS'(trial - {1'b0, dvs_ff});
         quo_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         dvs_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

[hw/rtl/outlier_trimmed_running_stats.sv]
// Top level: outlier-trimmed running mean and variance of cost samples.
//
// Input channel req_*: one cost sample per item. Result channel rsp_*: one
// result item per input item, in order: count, Q32.16 mean, Q48.16 sample
// variance, empty flag and sticky count-overflow flag.
// The largest OUTLIER_SLOTS samples are held back in a row of cells; only the
// value that drops out of that row is folded into the statistics.
// Steps: S_IDLE, S_VST, S_OUT while at most one sample has been folded; the
// variance division S_VDIV runs before S_OUT once more have; an item that
// folds into an existing mean first adds the mean division S_MDIV and the
// multiply/accumulate steps S_MUL and S_ACC. One item is in work at a time.
// req_stall is high while an item is in work. A finished result sits in the
// output register until taken; a new item may be accepted meanwhile, and its
// result is held back until the previous one has gone.
// Reset (synchronous) empties the slots and clears count, mean, sum and the
// overflow flag.
`timescale 1ns / 1ps
module outlier_trimmed_running_stats #(
   parameter int OUTLIER_SLOTS = otrs_pkg::OTRS_SLOTS,
   parameter int COST_BITS     = otrs_pkg::OTRS_COST_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_cost_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sample_count,
   output logic [47:0] rsp_mean_value,
   output logic [63:0] rsp_variance_value,
   output logic        rsp_stats_empty,
   output logic        rsp_count_overflow
);
   import otrs_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MDIV = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_ACC  = 3'd3;
   localparam logic [2:0] S_VST  = 3'd4;
   localparam logic [2:0] S_VDIV = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]  state_ff;
   logic [31:0] count_ff;
   logic [47:0] mean_ff, xq_ff, dabs_ff, b_ff;
   logic [63:0] sum_ff, var_ff;
   logic [95:0] acc_ff;
   logic [1:0]  k_ff;
   logic        dneg_ff, ovf_ff, rsp_valid_ff;

   logic [COST_BITS-1:0] sample;
   logic [COST_BITS-1:0] slot [OUTLIER_SLOTS];
   logic [COST_BITS-1:0] evicted;
   logic                 accept, displace;
   logic [47:0] xq, mnew, q48, eabs, dabs;
   logic [48:0] d, e;
   logic [63:0] pp, inc;
   logic [95:0] pp_sh;
   logic [64:0] sum_add;
   div_req_type dreq;
   div_rsp_type drsp;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign sample   = req_cost_sample[COST_BITS-1:0];
   assign displace = accept && (sample >= slot[0]);
   assign evicted  = (sample >= slot[0]) ? slot[0] : sample;

   for (genvar i = 0; i < OUTLIER_SLOTS; i++) begin : g_cell
      logic [COST_BITS-1:0] up;
      if (i == OUTLIER_SLOTS - 1) begin : g_top
         assign up = '1;
      end else begin : g_mid
         assign up = slot[i+1];
      end
      otrs_cell #(.W(COST_BITS)) u_cell (
         .clock (clock),
         .reset (reset),
         .load  (displace),
         .sample(sample),
         .upper (up),
         .value (slot[i])
      );
   end

   always_comb begin
      xq    = {32'(evicted), 16'h0000};
      d     = {1'b0, xq} - {1'b0, mean_ff};
      dabs  = d[48] ? 48'(-d) : d[47:0];
      q48   = drsp.quotient[47:0];
      mnew  = dneg_ff ? (mean_ff - q48) : (mean_ff + q48);
      e     = {1'b0, xq_ff} - {1'b0, mnew};
      eabs  = e[48] ? 48'(-e) : e[47:0];
      pp    = 64'(dabs_ff) * 64'(b_ff[15:0]);
      pp_sh = {32'h0, pp} << {k_ff, 4'h0};
      inc   = (acc_ff[95:80] != 16'h0) ? '1 : acc_ff[79:16];
      sum_add = {1'b0, sum_ff} + {1'b0, inc};
   end

   always_comb begin
      dreq = '0;
      if (state_ff == S_IDLE && accept && evicted != '0 && count_ff != '1
          && count_ff != '0) begin
         dreq.start    = 1'b1;
         dreq.dividend = 64'(dabs);
         dreq.divisor  = count_ff + 32'd1;
      end else if (state_ff == S_VST && count_ff > 32'd1) begin
         dreq.start    = 1'b1;
         dreq.dividend = sum_ff;
         dreq.divisor  = count_ff - 32'd1;
      end
   end

   otrs_div u_div (
      .clock(clock),
      .reset(reset),
      .req  (dreq),
      .rsp  (drsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mean_ff      <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // hold until the previous item has left the output register
         if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (evicted != '0) begin
                     if (count_ff == '1) begin
                        ovf_ff   <= 1'b1;
                        state_ff <= S_VST;
                     end else begin
                        count_ff <= count_ff + 32'd1;
                        if (count_ff == '0) begin
                           mean_ff  <= xq;
                           sum_ff   <= '0;
                           state_ff <= S_VST;
                        end else begin
                           state_ff <= S_MDIV;
                        end
                     end
                  end else begin
                     state_ff <= S_VST;
                  end
               end
            end
            S_MDIV: begin
               if (drsp.done) begin
                  mean_ff  <= mnew;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (k_ff == 2'd2) begin
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               sum_ff   <= sum_add[64] ? '1 : sum_add[63:0];
               state_ff <= S_VST;
            end
            S_VST: begin
               state_ff <= (count_ff > 32'd1) ? S_VDIV : S_OUT;
            end
            S_VDIV: begin
               if (drsp.done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && accept) begin
         xq_ff   <= xq;
         dabs_ff <= dabs;
         dneg_ff <= d[48];
      end
      if (state_ff == S_MDIV && drsp.done) begin
         acc_ff <= '0;
         b_ff   <= eabs;
         k_ff   <= 2'd0;
      end
      if (state_ff == S_MUL) begin
         acc_ff <= acc_ff + pp_sh;
         b_ff   <= {16'h0000, b_ff[47:16]};
         k_ff   <= k_ff + 2'd1;
      end
      if (state_ff == S_VST) begin
         var_ff <= '0;
      end
      if (state_ff == S_VDIV && drsp.done) begin
         var_ff <= drsp.quotient;
      end
      if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_sample_count   <= count_ff;
         rsp_mean_value     <= (count_ff != '0) ? mean_ff : '0;
         rsp_variance_value <= var_ff;
         rsp_stats_empty    <= (count_ff == '0);
         rsp_count_overflow <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
